/* src/arb_pkg.sv */
// ----------------------------------------------------------------------------
// arb_pkg
// Shared types and constants for the audio ring buffer with offset read.
// ----------------------------------------------------------------------------
package arb_pkg;

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 32;
  localparam int COUNT_W  = 7;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_READ  = 1'b1
  } arb_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_BURST
  } arb_state_t;

endpackage

/* src/arb_if.sv */
// ----------------------------------------------------------------------------
// arb_if
// Request and response channels of the audio ring buffer.
// ----------------------------------------------------------------------------
interface arb_req_if;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic signed [15:0]   sample_in;
  logic        [31:0]   read_head;
  logic signed [31:0]   offset;
  logic        [6:0]    count;

  modport source (output valid, kind, sample_in, read_head, offset, count, input ready);
  modport sink   (input valid, kind, sample_in, read_head, offset, count, output ready);
  modport monitor (input valid, ready, kind, sample_in, read_head, offset, count);
endinterface

interface arb_rsp_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   sample_out;
  logic                 from_store;
  logic        [6:0]    readable;
  logic                 last;

  modport source (output valid, sample_out, from_store, readable, last, input ready);
  modport sink   (input valid, sample_out, from_store, readable, last, output ready);
  modport monitor (input valid, ready, sample_out, from_store, readable, last);
endinterface

/* src/arb_ram.sv */
// ----------------------------------------------------------------------------
// arb_ram
// Single-port-write, single-port-read sample memory, registered read data.
// ----------------------------------------------------------------------------
module arb_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [arb_pkg::SAMPLE_W-1:0] wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [arb_pkg::SAMPLE_W-1:0] rdata
);
  import arb_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/arb_mod.sv */
// ----------------------------------------------------------------------------
// arb_mod
// Pipelined reduction of (head + signed offset) modulo DEPTH.
// Each operand is reduced by a reciprocal multiply, a back-multiply and one
// compare/subtract step; the two remainders are then folded into the base.
// ----------------------------------------------------------------------------
module arb_mod #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [arb_pkg::POS_W-1:0] head,
  input  logic [arb_pkg::POS_W-1:0] off,
  output logic                      done,
  output logic [AW-1:0]             base
);
  import arb_pkg::*;

  localparam logic [AW:0]      DEP_W  = (AW+1)'(DEPTH);
  localparam logic [AW+1:0]    DEP_1  = (AW+2)'(DEPTH);
  localparam logic [AW+1:0]    DEP_2  = (AW+2)'(2 * DEPTH);
  localparam logic [POS_W-1:0] DEP_P  = POS_W'(DEPTH);
  // floor((2^32 - 1) / DEPTH); the quotient estimate is low by at most two
  localparam logic [POS_W-1:0] RECIP  = POS_W'(64'hFFFF_FFFF / DEPTH);
  // 2^32 mod DEPTH, removed once when the offset is negative
  localparam longint unsigned C32_L = (64'd1 << 32) % DEPTH;
  localparam logic [AW:0] C32 = (AW+1)'(C32_L);

  logic [3:0]         vld;
  logic [POS_W-1:0]   h_op;
  logic [POS_W-1:0]   o_op;
  logic               neg;
  logic [POS_W-1:0]   h_q;
  logic [POS_W-1:0]   o_q;
  logic [AW+1:0]      h_d;
  logic [AW+1:0]      o_d;
  logic [AW-1:0]      rh;
  logic [AW-1:0]      ro;

  logic [2*POS_W-1:0] h_prod, o_prod;
  logic [POS_W-1:0]   h_diff, o_diff;
  logic [AW+1:0]      h_fix, o_fix;
  logic [AW:0]        sum, sum_red, fold;

  always_comb begin
    h_prod  = 64'(h_op) * 64'(RECIP);
    o_prod  = 64'(o_op) * 64'(RECIP);
    h_diff  = h_op - h_q * DEP_P;
    o_diff  = o_op - o_q * DEP_P;
    h_fix   = (h_d >= DEP_2) ? h_d - DEP_2 : ((h_d >= DEP_1) ? h_d - DEP_1 : h_d);
    o_fix   = (o_d >= DEP_2) ? o_d - DEP_2 : ((o_d >= DEP_1) ? o_d - DEP_1 : o_d);
    sum     = (AW+1)'(rh) + (AW+1)'(ro);
    sum_red = (sum >= DEP_W) ? sum - DEP_W : sum;
    if (!neg) begin
      fold = sum_red;
    end else if (sum_red >= C32) begin
      fold = sum_red - C32;
    end else begin
      fold = sum_red + DEP_W - C32;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[2:0], start};
      done <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      h_op <= head;
      o_op <= off;
      neg  <= off[POS_W-1];
    end
    h_q <= h_prod[2*POS_W-1:POS_W];
    o_q <= o_prod[2*POS_W-1:POS_W];
    h_d <= h_diff[AW+1:0];
    o_d <= o_diff[AW+1:0];
    rh  <= h_fix[AW-1:0];
    ro  <= o_fix[AW-1:0];
    if (vld[3]) begin
      base <= fold[AW-1:0];
    end
  end

endmodule

/* src/audio_ring_buffer_offset_read.sv */
// ----------------------------------------------------------------------------
// audio_ring_buffer_offset_read
// Circular store of 16-bit samples with a burst read at head + offset.
// ----------------------------------------------------------------------------
//  channel  dir  contents
//  req      in   kind, sample_in, read_head, offset, count
//  rsp      out  sample_out, from_store, readable, last
//
//  A write is taken in the idle state; the sample goes straight into the memory.
//  A read passes through the modulo unit (operand latch, two multiplies,
//  correction, fold), then issues one memory read per cycle while rsp does
//  not stall, one result each; req is held not ready from the request
//  transfer until the last read of the burst is issued.
//  The memory read register doubles as the output register; a stall on rsp
//  holds it and pauses the burst. Entries at or above the fill count read 0.
//  Reset is synchronous; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module audio_ring_buffer_offset_read #(
  parameter int DEPTH     = 4096,
  parameter int MAX_BURST = 64
) (
  input  logic       clk,
  input  logic       rst,
  arb_req_if.sink    req,
  arb_rsp_if.source  rsp
);
  import arb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = AW + 1;
  localparam logic [AW-1:0]      DEP_LAST = AW'(DEPTH - 1);
  localparam logic [FW-1:0]      DEP_F    = FW'(DEPTH);
  localparam logic [COUNT_W-1:0] BURST_W  = COUNT_W'(MAX_BURST);

  arb_state_t state, state_next;

  logic [AW-1:0]      wp;
  logic [FW-1:0]      fill;
  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W-1:0] rdbl;
  logic [COUNT_W-1:0] idx;
  logic [AW-1:0]      pos;

  logic               out_valid;
  logic               from_store_q;
  logic               entry_ok_q;
  logic               last_q;
  logic [COUNT_W-1:0] readable_q;

  logic               accept;
  logic               wr_en;
  logic               mod_start;
  logic               mod_done;
  logic [AW-1:0]      mod_base;
  logic               issue;
  logic [COUNT_W-1:0] cnt_sat;
  logic [COUNT_W-1:0] rdbl_calc;
  logic [SAMPLE_W-1:0] rdata;

  always_comb begin
    cnt_sat   = (req.count > BURST_W) ? BURST_W : req.count;
    rdbl_calc = ((COUNT_W + FW)'(fill) < (COUNT_W + FW)'(cnt_sat)) ?
                COUNT_W'(fill) : cnt_sat;
  end

  // outputs of the controller
  always_comb begin
    req.ready = (state == ST_IDLE);
    accept    = req.valid && req.ready;
    wr_en     = accept && (req.kind == KIND_WRITE);
    mod_start = accept && (req.kind == KIND_READ) && (cnt_sat != '0) && (fill != '0);
    issue     = (state == ST_BURST) && (!out_valid || rsp.ready);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (mod_start) state_next = ST_MOD;
      ST_MOD:   if (mod_done) state_next = ST_BURST;
      ST_BURST: if (issue && (idx + COUNT_W'(1) == cnt)) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        wp <= (wp == DEP_LAST) ? '0 : wp + AW'(1);
        if (fill != DEP_F) begin
          fill <= fill + FW'(1);
        end
      end
      if (issue) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mod_start) begin
      cnt  <= cnt_sat;
      rdbl <= rdbl_calc;
    end
    if (mod_done) begin
      pos <= mod_base;
      idx <= '0;
    end else if (issue) begin
      pos <= (pos == DEP_LAST) ? '0 : pos + AW'(1);
      idx <= idx + COUNT_W'(1);
    end
    if (issue) begin
      from_store_q <= (idx < rdbl);
      entry_ok_q   <= (CW'(pos) < CW'(fill));
      last_q       <= (idx + COUNT_W'(1) == cnt);
      readable_q   <= rdbl;
    end
  end

  arb_mod #(.DEPTH(DEPTH), .AW(AW)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .head  (req.read_head),
    .off   (req.offset),
    .done  (mod_done),
    .base  (mod_base)
  );

  arb_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wp),
    .wdata (req.sample_in),
    .re    (issue),
    .raddr (pos),
    .rdata (rdata)
  );

  assign rsp.valid      = out_valid;
  assign rsp.sample_out = (from_store_q && entry_ok_q) ? rdata : '0;
  assign rsp.from_store = from_store_q;
  assign rsp.readable   = readable_q;
  assign rsp.last       = last_q;

endmodule

/* src/arb_check.sv */
// ----------------------------------------------------------------------------
// arb_check
// Port-level checks for the audio ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module arb_check #(
  parameter int MAX_BURST = 64
) (
  input logic         clk,
  input logic         rst,
  arb_req_if.sink     req,
  arb_rsp_if.source   rsp
);
  import arb_pkg::*;

  localparam logic [COUNT_W-1:0] BURST_W = COUNT_W'(MAX_BURST);

  a_rst_idle: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("result valid right after reset");

  a_readable: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.readable != '0) && (rsp.readable <= BURST_W))
    else $error("readable out of range");

  a_tail: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ready && !rsp.from_store && !rsp.last
      |=> !rsp.valid || !rsp.from_store)
    else $error("store sample after zero tail");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.last |-> !req.ready)
    else $error("input taken in the middle of a burst");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.sample_out))
    else $error("stalled result dropped or changed");

endmodule

bind audio_ring_buffer_offset_read arb_check #(.MAX_BURST(MAX_BURST)) u_arb_check (
  .clk (clk),
  .rst (rst),
  .req (req),
  .rsp (rsp)
);

/* tb/audio_ring_buffer_offset_read_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_ring_buffer_offset_read_test
// Sends sample writes and burst reads through the request channel and checks
// every response transfer against a shadow copy of the sample store or fixed
// table values. A short table of hand-picked requests runs first, then random
// traffic, then a run of writes and reads with no idling on either side.
// ----------------------------------------------------------------------------
module audio_ring_buffer_offset_read_test;
  import arb_pkg::*;

  localparam int DEPTH        = 4096;
  localparam int MAX_BURST    = 64;
  localparam int RANDOM_ITEMS = 250;
  localparam int FINAL_WRITES = 16;
  localparam int TAIL_READS   = 24;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               from_store;
    logic [6:0]         readable;
    logic               last;
  } audio_word_t;

  // want_n < 0: results come from the shadow store
  typedef struct {
    arb_kind_t          kind;
    logic signed [15:0] sample;
    logic [31:0]        head;
    logic signed [31:0] offset;
    logic [6:0]         count;
    int                 want_n;
    logic signed [15:0] want_sample;
    logic [6:0]         want_readable;
  } req_row_t;

  logic clk;
  logic rst;

  arb_req_if req_bus ();
  arb_rsp_if rsp_bus ();

  audio_ring_buffer_offset_read #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  logic signed [15:0] shadow_store [DEPTH];
  logic [11:0]        shadow_wp;
  int                 shadow_fill;
  audio_word_t        burst_words_q [$];
  int                 mismatches;
  bit                 idling;
  req_row_t           directed [20];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("audio_ring_buffer_offset_read verification failed");
    $finish;
  end

  function automatic logic [11:0] store_index(logic [31:0] head, int i,
                                              logic signed [31:0] offset);
    longint pos;
    longint r;
    pos = longint'(head) + longint'(i) + longint'(offset);
    r = pos % DEPTH;
    if (r < 0) r += DEPTH;
    return r[11:0];
  endfunction

  task automatic predict_burst(input req_row_t r);
    int          n;
    int          rd;
    int          i;
    audio_word_t w;
    if (r.kind == KIND_WRITE) begin
      shadow_store[shadow_wp] = r.sample;
      shadow_wp = shadow_wp + 12'd1;
      if (shadow_fill < DEPTH) shadow_fill++;
    end else begin
      n = (r.count > MAX_BURST) ? MAX_BURST : int'(r.count);
      if (shadow_fill == 0) n = 0;
      rd = (n < shadow_fill) ? n : shadow_fill;
      if (r.want_n >= 0) begin
        n = r.want_n;
        rd = int'(r.want_readable);
      end
      for (i = 0; i < n; i++) begin
        w.from_store = (i < rd);
        if (i >= rd) w.sample = '0;
        else if (r.want_n >= 0) w.sample = r.want_sample;
        else w.sample = shadow_store[store_index(r.head, i, r.offset)];
        w.readable = rd[6:0];
        w.last = (i == n - 1);
        burst_words_q.push_back(w);
      end
    end
  endtask

  task automatic send_request(input req_row_t r);
    int gap;
    if (idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid     <= 1'b1;
    req_bus.kind      <= r.kind;
    req_bus.sample_in <= r.sample;
    req_bus.read_head <= r.head;
    req_bus.offset    <= r.offset;
    req_bus.count     <= r.count;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    predict_burst(r);
  endtask

  function automatic req_row_t random_row();
    req_row_t    r;
    int          pick;
    logic [31:0] target;
    r.sample        = 16'($urandom());
    r.head          = $urandom();
    r.offset        = $urandom();
    r.count         = 7'($urandom());
    r.want_n        = -1;
    r.want_sample   = '0;
    r.want_readable = '0;
    if ($urandom_range(0, 99) < 62) begin
      r.kind = KIND_WRITE;
      pick = $urandom_range(0, 9);
      if (pick == 0) r.sample = 16'sh7FFF;
      else if (pick == 1) r.sample = 16'sh8000;
      return r;
    end
    r.kind = KIND_READ;
    pick = $urandom_range(0, 15);
    if (pick == 0) r.count = 7'd0;
    else if (pick <= 10) r.count = 7'($urandom_range(1, 16));
    else if (pick <= 13) r.count = 7'($urandom_range(17, 64));
    else r.count = 7'($urandom_range(65, 127));
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      // land on recent writes; upper offset bits random
      target = 32'(shadow_wp) - 32'($urandom_range(1, 80));
      r.offset = target - r.head + ($urandom() << 12);
    end else if (pick < 8) begin
      r.head = $urandom_range(0, 8191);
      r.offset = 32'($urandom_range(0, 8191)) - 32'd4096;
    end
    return r;
  endfunction

  initial begin : rsp_pacer
    int stall_left;
    stall_left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    audio_word_t got;
    audio_word_t want;
    got = {rsp_bus.sample_out, rsp_bus.from_store, rsp_bus.readable, rsp_bus.last};
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (burst_words_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: sample %0d from_store %0b readable %0d last %0b",
                   got.sample, got.from_store, got.readable, got.last);
      end else begin
        want = burst_words_q.pop_front();
        if (got.sample !== want.sample || got.from_store !== want.from_store ||
            got.readable !== want.readable || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected sample %0d from_store %0b readable %0d last %0b,",
                      " got sample %0d from_store %0b readable %0d last %0b"},
                     want.sample, want.from_store, want.readable, want.last,
                     got.sample, got.from_store, got.readable, got.last);
        end
      end
    end
  end

  initial begin : stimulus
    int       i;
    req_row_t r;
    directed = '{
      '{KIND_READ,  16'sh0000, 32'h0000_0000, 32'sh0000_0000, 7'd5,    0, 16'sh0000, 7'd0},
      '{KIND_WRITE, 16'sh7FFF, 32'h0000_0000, 32'sh0000_0000, 7'd0,   -1, 16'sh0000, 7'd0},
      '{KIND_READ,  16'sh0000, 32'h0000_0000, 32'sh0000_0000, 7'd0,    0, 16'sh0000, 7'd0},
      '{KIND_READ,  16'sh0000, 32'h0000_0000, 32'sh0000_0000, 7'd3,    3, 16'sh7FFF, 7'd1},
      '{KIND_WRITE, 16'sh8000, 32'h0000_0000, 32'sh0000_0000, 7'd0,   -1, 16'sh0000, 7'd0},
      '{KIND_WRITE, 16'sh0000, 32'hFFFF_FFFF, 32'shFFFF_FFFF, 7'd127, -1, 16'sh0000, 7'd0},
      '{KIND_WRITE, 16'shFFFF, 32'h0000_0000, 32'sh0000_0000, 7'd0,   -1, 16'sh0000, 7'd0},
      '{KIND_READ,  16'sh1234, 32'h0000_0001, 32'sh0000_0000, 7'd1,    1, 16'sh8000, 7'd1},
      '{KIND_READ,  16'sh0000, 32'hFFFF_FFFF, 32'sh0000_0001, 7'd1,    1, 16'sh7FFF, 7'd1},
      '{KIND_READ,  16'sh0000, 32'h0000_0000, 32'sh8000_0000, 7'd1,    1, 16'sh7FFF, 7'd1},
      '{KIND_READ,  16'sh0000, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 7'd1,    1, 16'sh0000, 7'd1},
      '{KIND_READ,  16'sh0000, 32'h0000_0003, -32'sd3,        7'd1,    1, 16'sh7FFF, 7'd1},
      '{KIND_READ,  16'sh0000, 32'h0000_0000, -32'sd1,        7'd4,   -1, 16'sh0000, 7'd0},
      '{KIND_READ,  16'sh0000, 32'h0000_0000, 32'sh0000_0000, 7'd127, -1, 16'sh0000, 7'd0},
      '{KIND_READ,  16'sh7FFF, 32'h0000_0002, 32'sh0000_0000, 7'd2,   -1, 16'sh0000, 7'd0},
      '{KIND_WRITE, 16'sh5555, 32'h0000_0000, 32'sh0000_0000, 7'd0,   -1, 16'sh0000, 7'd0},
      '{KIND_WRITE, 16'shAAAA, 32'h0000_0000, 32'sh0000_0000, 7'd0,   -1, 16'sh0000, 7'd0},
      '{KIND_READ,  16'sh0000, 32'h0000_0064, -32'sd100,      7'd7,   -1, 16'sh0000, 7'd0},
      '{KIND_READ,  16'sh0000, 32'h0000_0000, 32'sh0000_0000, 7'd64,  -1, 16'sh0000, 7'd0},
      '{KIND_READ,  16'sh0000, 32'h0000_0000, 32'sh0000_0000, 7'd65,  -1, 16'sh0000, 7'd0}
    };
    mismatches  = 0;
    idling      = 1'b1;
    shadow_wp   = '0;
    shadow_fill = 0;
    for (i = 0; i < DEPTH; i++) shadow_store[i] = '0;

    rst               <= 1'b1;
    req_bus.valid     <= 1'b0;
    req_bus.kind      <= KIND_WRITE;
    req_bus.sample_in <= '0;
    req_bus.read_head <= '0;
    req_bus.offset    <= '0;
    req_bus.count     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[k]) send_request(directed[k]);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) idling = ($urandom_range(0, 3) != 0);
      send_request(random_row());
    end

    // no idling from here on
    idling = 1'b0;
    for (i = 0; i < FINAL_WRITES; i++) begin
      r = random_row();
      r.kind = KIND_WRITE;
      send_request(r);
    end
    for (i = 0; i < TAIL_READS; i++) begin
      r = random_row();
      while (r.kind != KIND_READ) r = random_row();
      send_request(r);
    end
    req_bus.valid <= 1'b0;

    while (burst_words_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("audio_ring_buffer_offset_read verification clean");
    end else begin
      $display("audio_ring_buffer_offset_read verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/arb_pkg.sv
src/arb_if.sv
src/arb_ram.sv
src/arb_mod.sv
src/audio_ring_buffer_offset_read.sv
src/arb_check.sv
tb/audio_ring_buffer_offset_read_test.sv
